>>> rtl/mlfpd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlfpd_pkg
// Shared types, constants and the microcode table of the LED PWM dimmer.
// ----------------------------------------------------------------------------
package mlfpd_pkg;

    localparam int KIND_W    = 2;
    localparam int CHAN_W    = 3;
    localparam int LEVEL_W   = 8;
    localparam int BRIGHT_W  = 7;
    localparam int MODES_W   = 16;
    localparam int MASK_W    = 8;
    localparam int UPC_W     = 3;

    localparam logic [BRIGHT_W-1:0] FULL_LEVEL = 7'd100;
    localparam logic [LEVEL_W-1:0]  FOLD_LEVEL = 8'd200;

    localparam logic [KIND_W-1:0] KIND_PWM  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FADE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SET  = 2'd2;

    localparam logic [1:0] MODE_BOTH = 2'd0;
    localparam logic [1:0] MODE_UP   = 2'd1;
    localparam logic [1:0] MODE_DOWN = 2'd2;

    localparam logic [UPC_W-1:0] UA_IDLE  = 3'd0;
    localparam logic [UPC_W-1:0] UA_PHASE = 3'd1;
    localparam logic [UPC_W-1:0] UA_PWM   = 3'd2;
    localparam logic [UPC_W-1:0] UA_FADE  = 3'd3;
    localparam logic [UPC_W-1:0] UA_SET   = 3'd4;
    localparam logic [UPC_W-1:0] UA_EMIT  = 3'd5;

    typedef enum logic [2:0] {
        UOP_NOP,
        UOP_WAIT,
        UOP_PHASE,
        UOP_PWM,
        UOP_FADE,
        UOP_SET,
        UOP_EMIT
    } uop_t;

    typedef enum logic [1:0] {
        SEQ_NEXT,
        SEQ_JUMP,
        SEQ_LOOP,
        SEQ_DISPATCH
    } seq_t;

    typedef struct packed {
        uop_t              op;
        seq_t              seq;
        logic [UPC_W-1:0]  jump;
    } ucode_t;

    typedef struct packed {
        uop_t op;
        logic start;
    } ctrl_t;

    function automatic ucode_t ucode_rom(input logic [UPC_W-1:0] addr);
        ucode_t w;
        case (addr)
            UA_IDLE:  w = '{op: UOP_WAIT,  seq: SEQ_DISPATCH, jump: UA_IDLE};
            UA_PHASE: w = '{op: UOP_PHASE, seq: SEQ_NEXT,     jump: UA_PWM};
            UA_PWM:   w = '{op: UOP_PWM,   seq: SEQ_LOOP,     jump: UA_EMIT};
            UA_FADE:  w = '{op: UOP_FADE,  seq: SEQ_LOOP,     jump: UA_EMIT};
            UA_SET:   w = '{op: UOP_SET,   seq: SEQ_JUMP,     jump: UA_EMIT};
            UA_EMIT:  w = '{op: UOP_EMIT,  seq: SEQ_JUMP,     jump: UA_IDLE};
            default:  w = '{op: UOP_NOP,   seq: SEQ_JUMP,     jump: UA_IDLE};
        endcase
        return w;
    endfunction

endpackage

>>> rtl/mlfpd_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlfpd_sequencer
// Step counter, channel counter and microcode table; issues one control
// word per cycle to the datapath.
// ----------------------------------------------------------------------------
module mlfpd_sequencer #(
    parameter int CHANNELS = 8,
    localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        in_valid,
    input  logic [mlfpd_pkg::KIND_W-1:0] in_kind,
    input  logic                        out_busy,
    output logic                        in_ready,
    output mlfpd_pkg::ctrl_t            ctrl,
    output logic [CW-1:0]               ch_idx
);
    import mlfpd_pkg::*;

    localparam logic [CW-1:0] LAST_CH = CW'(CHANNELS - 1);

    logic [UPC_W-1:0] upc_reg, upc_next;
    logic [CW-1:0]    ch_reg, ch_next;
    ucode_t           uw;
    logic [UPC_W-1:0] entry;

    always_comb begin
        case (in_kind)
            KIND_PWM:  entry = UA_PHASE;
            KIND_FADE: entry = UA_FADE;
            KIND_SET:  entry = UA_SET;
            default:   entry = UA_EMIT;
        endcase
    end

    always_comb begin
        uw         = ucode_rom(upc_reg);
        upc_next   = upc_reg;
        ch_next    = ch_reg;
        in_ready   = 1'b0;
        ctrl.op    = uw.op;
        ctrl.start = 1'b0;
        case (uw.seq)
            SEQ_DISPATCH: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    upc_next   = entry;
                    ch_next    = '0;
                    ctrl.start = 1'b1;
                end
            end
            SEQ_LOOP: begin
                if (ch_reg == LAST_CH) begin
                    upc_next = uw.jump;
                    ch_next  = '0;
                end else begin
                    ch_next = ch_reg + 1'b1;
                end
            end
            SEQ_JUMP: begin
                // hold the emit step while the output register is full
                if (!(uw.op == UOP_EMIT && out_busy)) begin
                    upc_next = uw.jump;
                end
            end
            default: begin
                upc_next = upc_reg + 1'b1;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upc_reg <= UA_IDLE;
            ch_reg  <= '0;
        end else begin
            upc_reg <= upc_next;
            ch_reg  <= ch_next;
        end
    end

    assign ch_idx = ch_reg;

endmodule

>>> rtl/mlfpd_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlfpd_datapath
// Channel state, phase counter and lit flags; one channel updated per step.
// ----------------------------------------------------------------------------
module mlfpd_datapath #(
    parameter int CHANNELS = 8,
    localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  mlfpd_pkg::ctrl_t              ctrl,
    input  logic [CW-1:0]                 ch_idx,
    input  logic                          cfg_wr_en,
    input  logic [mlfpd_pkg::MODES_W-1:0] cfg_wr_data,
    input  logic [mlfpd_pkg::CHAN_W-1:0]  set_channel,
    input  logic [mlfpd_pkg::LEVEL_W-1:0] set_level,
    output logic [mlfpd_pkg::MASK_W-1:0]  lit_mask,
    output logic                          wrapped
);
    import mlfpd_pkg::*;

    logic [BRIGHT_W-1:0] bright_reg [CHANNELS];
    logic [BRIGHT_W-1:0] target_reg [CHANNELS];
    logic [BRIGHT_W-1:0] phase_reg, phase_next;
    logic                wrap_reg;
    logic [CHANNELS-1:0] lit_reg;
    logic [MODES_W-1:0]  modes_reg;

    logic [BRIGHT_W-1:0] b_cur, t_cur, b_step, b_new, t_new;
    logic [4:0]          ch_wide, set_wide;
    logic [1:0]          mode;
    logic [BRIGHT_W-1:0] fold_level;

    assign b_cur    = bright_reg[ch_idx];
    assign t_cur    = target_reg[ch_idx];
    assign ch_wide  = 5'(ch_idx);
    assign set_wide = 5'(set_channel);
    assign mode     = (ch_wide < 5'd8) ? 2'(modes_reg >> {ch_wide[2:0], 1'b0}) : MODE_BOTH;
    assign phase_next = phase_reg + 1'b1;

    always_comb begin
        if (set_level > FOLD_LEVEL) begin
            fold_level = '0;
        end else if (set_level > LEVEL_W'(FULL_LEVEL)) begin
            fold_level = BRIGHT_W'(FOLD_LEVEL - set_level);
        end else begin
            fold_level = BRIGHT_W'(set_level);
        end
    end

    always_comb begin
        b_step = b_cur;
        b_new  = b_cur;
        t_new  = t_cur;
        case (mode)
            MODE_BOTH: begin
                if (t_cur > b_cur) begin
                    b_new = b_cur + 1'b1;
                end else if (t_cur < b_cur) begin
                    b_new = b_cur - 1'b1;
                end
            end
            MODE_UP: begin
                if (b_cur < FULL_LEVEL) begin
                    b_step = b_cur + 1'b1;
                end
                b_new = b_step;
                if (t_cur < b_step) begin
                    b_new = t_cur;
                    t_new = FULL_LEVEL;
                end
            end
            MODE_DOWN: begin
                if (b_cur != '0) begin
                    b_step = b_cur - 1'b1;
                end
                b_new = b_step;
                if (t_cur > b_step) begin
                    b_new = t_cur;
                    t_new = '0;
                end
            end
            default: begin
                b_new = t_cur;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < CHANNELS; i++) begin
                bright_reg[i] <= '0;
                target_reg[i] <= '0;
            end
            phase_reg <= BRIGHT_W'(1);
            wrap_reg  <= 1'b0;
            lit_reg   <= '0;
            modes_reg <= '0;
        end else begin
            if (cfg_wr_en) begin
                modes_reg <= cfg_wr_data;
            end
            if (ctrl.start) begin
                wrap_reg <= 1'b0;
            end
            case (ctrl.op)
                UOP_PHASE: begin
                    if (phase_next > FULL_LEVEL) begin
                        phase_reg <= BRIGHT_W'(1);
                        wrap_reg  <= 1'b1;
                    end else begin
                        phase_reg <= phase_next;
                    end
                end
                UOP_PWM: begin
                    if (wrap_reg) begin
                        lit_reg[ch_idx] <= (b_cur > BRIGHT_W'(1));
                    end else if (lit_reg[ch_idx] && b_cur <= phase_reg) begin
                        lit_reg[ch_idx] <= 1'b0;
                    end
                end
                UOP_FADE: begin
                    bright_reg[ch_idx] <= b_new;
                    target_reg[ch_idx] <= t_new;
                end
                UOP_SET: begin
                    if (set_wide < 5'(CHANNELS)) begin
                        target_reg[set_wide[CW-1:0]] <= fold_level;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign lit_mask = MASK_W'(lit_reg);
    assign wrapped  = wrap_reg;

endmodule

>>> rtl/multi_led_fading_pwm_dimmer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_led_fading_pwm_dimmer_unit
// Multi-channel LED dimmer with fade modes and a phase-counter PWM.
// ----------------------------------------------------------------------------
// Every item ends in the emit step: a pwm tick first steps the phase and visits
// every channel's lit flag, a fade tick visits every channel's brightness, set
// level writes one target. The loop visits one channel a cycle. The result waits
// in an output register; the emit step holds while that register is still full.
// Synchronous active-low reset: brightness and targets zero, phase one,
// all lit flags off, channel modes zero.
// ----------------------------------------------------------------------------
module multi_led_fading_pwm_dimmer_unit #(
    parameter int CHANNELS = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,   // channel_modes
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,       // channel[2:0], level[10:3], zero fill
    input  logic [1:0]  s_tuser,       // kind[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata        // lit_mask[7:0], period_start[8], zero fill
);
    import mlfpd_pkg::*;

    localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    ctrl_t               ctrl;
    logic [CW-1:0]       ch_idx;
    logic                out_busy;
    logic [CHAN_W-1:0]   chan_reg;
    logic [LEVEL_W-1:0]  level_reg;
    logic [MASK_W-1:0]   lit_mask;
    logic                wrapped;
    logic                out_valid_reg;
    logic [15:0]         out_data_reg;

    assign out_busy = out_valid_reg && !m_tready;

    mlfpd_sequencer #(.CHANNELS(CHANNELS)) u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_kind  (s_tuser),
        .out_busy (out_busy),
        .in_ready (s_tready),
        .ctrl     (ctrl),
        .ch_idx   (ch_idx)
    );

    mlfpd_datapath #(.CHANNELS(CHANNELS)) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctrl        (ctrl),
        .ch_idx      (ch_idx),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .set_channel (chan_reg),
        .set_level   (level_reg),
        .lit_mask    (lit_mask),
        .wrapped     (wrapped)
    );

    always_ff @(posedge aclk) begin
        if (ctrl.start) begin
            chan_reg  <= s_tdata[2:0];
            level_reg <= s_tdata[10:3];
        end
        if (ctrl.op == UOP_EMIT && !out_busy) begin
            out_data_reg <= {7'd0, wrapped, lit_mask};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (ctrl.op == UOP_EMIT && !out_busy) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule
